@@ rtl/core/sst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, codes and constants of the slideshow hold/transition sequencer.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_IMAGES_DEF = 256;
    localparam int unsigned TICK_MS_DEF    = 33;

    // Fixed field widths
    localparam int unsigned COUNT_W   = 9;
    localparam int unsigned TIME_W    = 20;
    localparam int unsigned INDEX_W   = 8;
    localparam int unsigned ELAPSED_W = 21;
    localparam int unsigned LEVEL_IN_W = 16;
    localparam int unsigned LEVEL_W   = 13;
    localparam int unsigned TOTAL_W   = 29;
    localparam int unsigned PROD_W    = COUNT_W + TIME_W + 1;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [LEVEL_W-1:0]   FULL_LEVEL  = 13'd4096;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 21'h1FFFFF;
    localparam logic [PROD_W-1:0]    TOTAL_MAX   = 30'h1FFFFFFF;

    // Register reset values
    localparam logic [TIME_W-1:0] SLIDE_MS_RST      = 20'd3000;
    localparam logic [TIME_W-1:0] TRANSITION_MS_RST = 20'd1000;

    // Progress divider: quotient bits below the full-scale bit
    localparam int unsigned DIV_STEPS  = 12;
    localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

    // Item queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_LEVEL = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_COUNT   = 3'd0,
        CFG_SLIDE_MS      = 3'd1,
        CFG_TRANSITION_MS = 3'd2,
        CFG_CUT_MODE      = 3'd3,
        CFG_LOOP_ENABLE   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_CALC = 2'd1,
        B_DONE = 2'd2
    } back_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] image_count;
        logic [TIME_W-1:0]  slide_ms;
        logic [TIME_W-1:0]  transition_ms;
        logic               cut_mode;
        logic               loop_enable;
    } cfg_t;

    // State snapshot after one event
    typedef struct packed {
        logic                 running;
        logic                 finished;
        logic [INDEX_W-1:0]   shown;
        logic                 in_trans;
        logic [INDEX_W-1:0]   target;
        logic [ELAPSED_W-1:0] elapsed;
        logic [LEVEL_W-1:0]   level;
    } sst_item_t;

    // Image count limited to the supported maximum
    function automatic logic [COUNT_W-1:0] eff_count(logic [COUNT_W-1:0] cnt,
                                                     int unsigned max_images);
        logic [COUNT_W-1:0] res;
        if (32'(cnt) > max_images)
            res = COUNT_W'(max_images);
        else
            res = cnt;
        return res;
    endfunction

endpackage

@@ rtl/core/sst_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_front
// Accepts events, classifies them and updates the show state;
// each updated state goes into the item queue.
// ----------------------------------------------------------------------------
module sst_front #(
    parameter int unsigned MAX_IMAGES = sst_pkg::MAX_IMAGES_DEF,
    parameter int unsigned TICK_MS    = sst_pkg::TICK_MS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sst_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       func,
    input  logic [sst_pkg::LEVEL_IN_W-1:0]   level_in,
    input  logic                             q_full,
    output logic                             q_push,
    output sst_pkg::sst_item_t               q_item
);

    logic                            running_reg, running_next;
    logic                            trans_reg, trans_next;
    logic [sst_pkg::INDEX_W-1:0]     shown_reg, shown_next;
    logic [sst_pkg::INDEX_W-1:0]     target_reg, target_next;
    logic [sst_pkg::ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [sst_pkg::LEVEL_W-1:0]     level_reg, level_next;
    logic                            fin;

    logic [sst_pkg::COUNT_W-1:0]     n;
    logic [sst_pkg::ELAPSED_W:0]     elapsed_sum;
    logic [sst_pkg::ELAPSED_W-1:0]   elapsed_sat;
    logic [sst_pkg::COUNT_W-1:0]     nxt;
    logic [sst_pkg::TIME_W-1:0]      eff_trans;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    assign n           = sst_pkg::eff_count(cfg.image_count, MAX_IMAGES);
    assign elapsed_sum = {1'b0, elapsed_reg} + (sst_pkg::ELAPSED_W + 1)'(TICK_MS);
    assign elapsed_sat = elapsed_sum[sst_pkg::ELAPSED_W] ? sst_pkg::ELAPSED_MAX
                                                        : elapsed_sum[sst_pkg::ELAPSED_W-1:0];
    assign nxt         = {1'b0, shown_reg} + sst_pkg::COUNT_W'(1);
    assign eff_trans   = cfg.cut_mode ? '0 : cfg.transition_ms;

    // Event decode and next state
    always_comb
    begin
        running_next = running_reg;
        trans_next   = trans_reg;
        shown_next   = shown_reg;
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        level_next   = level_reg;
        fin          = 1'b0;
        unique case (sst_pkg::func_t'(func))
            sst_pkg::FUNC_START:
            begin
                if (n == '0)
                begin
                    running_next = 1'b0;
                    fin          = 1'b1;
                end
                else
                begin
                    shown_next   = '0;
                    target_next  = '0;
                    trans_next   = 1'b0;
                    elapsed_next = '0;
                    level_next   = sst_pkg::FULL_LEVEL;
                    running_next = 1'b1;
                end
            end
            sst_pkg::FUNC_STOP:
            begin
                running_next = 1'b0;
                level_next   = sst_pkg::FULL_LEVEL;
            end
            sst_pkg::FUNC_TICK:
            begin
                if (running_reg)
                begin
                    if (n == '0)
                    begin
                        running_next = 1'b0;
                        fin          = 1'b1;
                    end
                    else
                    begin
                        elapsed_next = elapsed_sat;
                        if (!trans_reg)
                        begin
                            if (elapsed_sat >= {1'b0, cfg.slide_ms})
                            begin
                                if (nxt >= n)
                                begin
                                    if (cfg.loop_enable)
                                    begin
                                        target_next  = '0;
                                        trans_next   = 1'b1;
                                        elapsed_next = '0;
                                    end
                                    else
                                    begin
                                        running_next = 1'b0;
                                        fin          = 1'b1;
                                    end
                                end
                                else
                                begin
                                    target_next  = nxt[sst_pkg::INDEX_W-1:0];
                                    trans_next   = 1'b1;
                                    elapsed_next = '0;
                                end
                            end
                        end
                        else if (elapsed_sat >= {1'b0, eff_trans})
                        begin
                            shown_next   = target_reg;
                            trans_next   = 1'b0;
                            elapsed_next = '0;
                        end
                    end
                end
            end
            sst_pkg::FUNC_LEVEL:
            begin
                if (level_in > 16'(sst_pkg::FULL_LEVEL))
                    level_next = sst_pkg::FULL_LEVEL;
                else
                    level_next = level_in[sst_pkg::LEVEL_W-1:0];
            end
            default: ;
        endcase
    end

    // Snapshot handed to the back end
    always_comb
    begin
        q_item.running  = running_next;
        q_item.finished = fin;
        q_item.shown    = shown_next;
        q_item.in_trans = trans_next;
        q_item.target   = target_next;
        q_item.elapsed  = elapsed_next;
        q_item.level    = level_next;
    end

    // State registers, updated only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            trans_reg   <= 1'b0;
            shown_reg   <= '0;
            target_reg  <= '0;
            elapsed_reg <= '0;
            level_reg   <= sst_pkg::FULL_LEVEL;
        end
        else if (q_push)
        begin
            running_reg <= running_next;
            trans_reg   <= trans_next;
            shown_reg   <= shown_next;
            target_reg  <= target_next;
            elapsed_reg <= elapsed_next;
            level_reg   <= level_next;
        end
    end

endmodule

@@ rtl/core/sst_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_queue
// Short FIFO of state snapshots between the front and the back end.
// ----------------------------------------------------------------------------
module sst_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sst_pkg::sst_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output sst_pkg::sst_item_t head_item
);

    sst_pkg::sst_item_t                  entry_reg [sst_pkg::QUEUE_DEPTH];
    logic [sst_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [sst_pkg::QUEUE_PTR_W:0]       count_reg, count_next;

    assign full      = (count_reg == (sst_pkg::QUEUE_PTR_W + 1)'(sst_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/core/sst_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_back
// Takes snapshots from the queue, works out progress with a restoring
// divider and the total show time, and holds the result in an output register.
// ----------------------------------------------------------------------------
module sst_back #(
    parameter int unsigned MAX_IMAGES = sst_pkg::MAX_IMAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sst_pkg::cfg_t                  cfg,
    input  logic                           q_not_empty,
    input  sst_pkg::sst_item_t             q_item,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           playing,
    output logic                           finished,
    output logic [sst_pkg::INDEX_W-1:0]    current_image,
    output logic                           next_valid,
    output logic [sst_pkg::INDEX_W-1:0]    next_image,
    output logic [sst_pkg::LEVEL_W-1:0]    progress,
    output logic [sst_pkg::LEVEL_W-1:0]    level_out,
    output logic [sst_pkg::TOTAL_W-1:0]    total_ms
);

    sst_pkg::back_state_t              state_reg, state_next;
    sst_pkg::sst_item_t                item_reg;
    logic [sst_pkg::ELAPSED_W-1:0]     rem_reg;
    logic [sst_pkg::DIV_STEPS-1:0]     quo_reg;
    logic [sst_pkg::DIV_STEP_W-1:0]    step_reg;
    logic                              full_reg;
    logic [sst_pkg::PROD_W-1:0]        prod_reg;
    logic                              out_valid_reg;

    logic                              load_item;
    logic                              div_step;
    logic                              load_out;
    logic                              last_step;

    logic [sst_pkg::TIME_W-1:0]        d;
    logic [sst_pkg::ELAPSED_W-1:0]     rem_shift;
    logic                              rem_ge;
    logic [sst_pkg::COUNT_W-1:0]       n;
    logic [sst_pkg::TIME_W:0]          st_sum;
    logic [sst_pkg::PROD_W-1:0]        total_diff;
    logic [sst_pkg::TOTAL_W-1:0]       total_val;
    logic [sst_pkg::LEVEL_W-1:0]       prog_val;

    assign d         = cfg.cut_mode ? '0 : cfg.transition_ms;
    assign rem_shift = {rem_reg[sst_pkg::ELAPSED_W-2:0], 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, d});
    assign last_step = (step_reg == sst_pkg::DIV_STEP_W'(sst_pkg::DIV_STEPS - 1));
    assign n         = sst_pkg::eff_count(cfg.image_count, MAX_IMAGES);
    assign st_sum    = {1'b0, cfg.slide_ms} + {1'b0, cfg.transition_ms};

    // Total: n*(slide+trans) - trans, saturated
    assign total_diff = prod_reg - sst_pkg::PROD_W'(cfg.transition_ms);
    always_comb
    begin
        if (n == '0)
            total_val = '0;
        else if (total_diff > sst_pkg::TOTAL_MAX)
            total_val = sst_pkg::TOTAL_MAX[sst_pkg::TOTAL_W-1:0];
        else
            total_val = total_diff[sst_pkg::TOTAL_W-1:0];
    end

    // Progress selection
    always_comb
    begin
        if (!item_reg.in_trans)
            prog_val = '0;
        else if (full_reg)
            prog_val = sst_pkg::FULL_LEVEL;
        else
            prog_val = {1'b0, quo_reg};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sst_pkg::B_IDLE: if (q_not_empty) state_next = sst_pkg::B_CALC;
            sst_pkg::B_CALC: if (last_step) state_next = sst_pkg::B_DONE;
            sst_pkg::B_DONE: if (!out_valid_reg || out_ready) state_next = sst_pkg::B_IDLE;
            default:         state_next = sst_pkg::B_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        load_item = 1'b0;
        div_step  = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            sst_pkg::B_IDLE: load_item = q_not_empty;
            sst_pkg::B_CALC: div_step  = 1'b1;
            sst_pkg::B_DONE: load_out  = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign q_pop = load_item;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_item)
                step_reg <= '0;
            else if (div_step)
                step_reg <= step_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Divider and total datapath
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= q_item;
            rem_reg  <= q_item.elapsed;
            quo_reg  <= '0;
            full_reg <= (d == '0) || (q_item.elapsed >= {1'b0, d});
        end
        else if (div_step)
        begin
            prod_reg <= sst_pkg::PROD_W'(n) * sst_pkg::PROD_W'(st_sum);
            if (rem_ge)
            begin
                rem_reg <= rem_shift - {1'b0, d};
                quo_reg <= {quo_reg[sst_pkg::DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[sst_pkg::DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            playing       <= item_reg.running;
            finished      <= item_reg.finished;
            current_image <= item_reg.shown;
            next_valid    <= item_reg.in_trans;
            next_image    <= item_reg.in_trans ? item_reg.target : '0;
            progress      <= prog_val;
            level_out     <= item_reg.level;
            total_ms      <= total_val;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/slideshow_hold_transition_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slideshow_hold_transition_sequencer
// Event-driven slideshow sequencer: front end updates the show state per event,
// back end computes progress and total time and delivers one result per event.
// ----------------------------------------------------------------------------
// Path: item queue, back-end load in B_IDLE, 12-step progress divider in B_CALC,
// output register in B_DONE. The back end takes the next item only from B_IDLE.
// The front accepts back to back until the 4-entry item queue fills.
// Reset: asynchronous, active low; show idle at full level, registers at
// their defaults (count 0, slide 3000 ms, transition 1000 ms, cut/loop off).
// ----------------------------------------------------------------------------
module slideshow_hold_transition_sequencer #(
    parameter int unsigned MAX_IMAGES = sst_pkg::MAX_IMAGES_DEF,
    parameter int unsigned TICK_MS    = sst_pkg::TICK_MS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sst_pkg::TIME_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      func,
    input  logic [sst_pkg::LEVEL_IN_W-1:0]  level_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            playing,
    output logic                            finished,
    output logic [sst_pkg::INDEX_W-1:0]     current_image,
    output logic                            next_valid,
    output logic [sst_pkg::INDEX_W-1:0]     next_image,
    output logic [sst_pkg::LEVEL_W-1:0]     progress,
    output logic [sst_pkg::LEVEL_W-1:0]     level_out,
    output logic [sst_pkg::TOTAL_W-1:0]     total_ms
);

    sst_pkg::cfg_t       cfg_reg;
    sst_pkg::sst_item_t  push_item, head_item;
    logic                q_push, q_pop, q_full, q_not_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_count   <= '0;
            cfg_reg.slide_ms      <= sst_pkg::SLIDE_MS_RST;
            cfg_reg.transition_ms <= sst_pkg::TRANSITION_MS_RST;
            cfg_reg.cut_mode      <= 1'b0;
            cfg_reg.loop_enable   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sst_pkg::CFG_IMAGE_COUNT:
                    cfg_reg.image_count <= cfg_data[sst_pkg::COUNT_W-1:0];
                sst_pkg::CFG_SLIDE_MS:      cfg_reg.slide_ms      <= cfg_data;
                sst_pkg::CFG_TRANSITION_MS: cfg_reg.transition_ms <= cfg_data;
                sst_pkg::CFG_CUT_MODE:      cfg_reg.cut_mode      <= cfg_data[0];
                sst_pkg::CFG_LOOP_ENABLE:   cfg_reg.loop_enable   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sst_front #(
        .MAX_IMAGES (MAX_IMAGES),
        .TICK_MS    (TICK_MS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .level_in (level_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    sst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    sst_back #(
        .MAX_IMAGES (MAX_IMAGES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_not_empty   (q_not_empty),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .playing       (playing),
        .finished      (finished),
        .current_image (current_image),
        .next_valid    (next_valid),
        .next_image    (next_image),
        .progress      (progress),
        .level_out     (level_out),
        .total_ms      (total_ms)
    );

    // A finished show is never reported as playing
    a_fin_not_playing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> !playing)
        else $error("finished result reports playing");

    // Holding phase reports no progress and no next image
    a_hold_no_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !next_valid) |-> (progress == '0 && next_image == '0))
        else $error("holding result with nonzero progress or next image");

    // Progress and level stay within full scale
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (progress <= sst_pkg::FULL_LEVEL && level_out <= sst_pkg::FULL_LEVEL))
        else $error("progress or level above full scale");

    // Queue never pops when empty
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("queue popped while empty");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slideshow hold/transition sequencer. A queue of
// events feeds a bursty valid/ready driver. Every accepted event runs through
// a local model of the show, and each result is compared field by field in
// order. The run covers directed corner cases, a full 256-image looping run
// and random phases, with a stalling receiver and config changes while idle.
// ----------------------------------------------------------------------------
module testbench;
    import sst_pkg::*;

    localparam int unsigned TICK_STEP       = TICK_MS_DEF;
    localparam int unsigned IMAGE_LIMIT     = MAX_IMAGES_DEF;
    localparam int unsigned ITEM_TARGET     = 1150;
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned HOLD_OFF_CYCLES = 240;
    localparam int unsigned HOLD_OFF_PERIOD = 5000;
    localparam int unsigned SETTLE_CYCLES   = 24;
    localparam logic [63:0] TOTAL_SAT       = 64'h1FFF_FFFF;

    typedef struct {
        func_t                 kind;
        logic [LEVEL_IN_W-1:0] level;
    } show_event_t;

    typedef struct {
        logic               playing;
        logic               finished;
        logic [INDEX_W-1:0] current_image;
        logic               next_valid;
        logic [INDEX_W-1:0] next_image;
        logic [LEVEL_W-1:0] progress;
        logic [LEVEL_W-1:0] level_out;
        logic [TOTAL_W-1:0] total_ms;
    } show_frame_t;

    // DUT connections
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TIME_W-1:0]     cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [1:0]            func      = '0;
    logic [LEVEL_IN_W-1:0] level_in  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  playing;
    logic                  finished;
    logic [INDEX_W-1:0]    current_image;
    logic                  next_valid;
    logic [INDEX_W-1:0]    next_image;
    logic [LEVEL_W-1:0]    progress;
    logic [LEVEL_W-1:0]    level_out;
    logic [TOTAL_W-1:0]    total_ms;

    // Show model: registers and state
    logic [COUNT_W-1:0]    cfg_count;
    logic [TIME_W-1:0]     cfg_slide;
    logic [TIME_W-1:0]     cfg_trans;
    logic                  cfg_cut;
    logic                  cfg_loop;
    logic                  show_running;
    logic                  show_in_trans;
    logic [INDEX_W-1:0]    show_shown;
    logic [INDEX_W-1:0]    show_target;
    logic [ELAPSED_W-1:0]  show_elapsed;
    logic [LEVEL_W-1:0]    show_level;

    show_event_t pending_events[$];
    show_frame_t expected_frames[$];
    show_event_t next_event;
    show_frame_t arrived_want;

    int unsigned events_queued   = 0;
    int unsigned events_accepted = 0;
    int unsigned ticks_seen      = 0;
    int unsigned show_ends       = 0;
    int unsigned show_wraps      = 0;
    int unsigned top_image       = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned gap_left        = 0;
    int unsigned burst_left      = 4;
    int unsigned hold_off_left   = 0;
    int unsigned rcv_cycles      = 0;
    int unsigned ready_mode      = 0;

    slideshow_hold_transition_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .level_in      (level_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .playing       (playing),
        .finished      (finished),
        .current_image (current_image),
        .next_valid    (next_valid),
        .next_image    (next_image),
        .progress      (progress),
        .level_out     (level_out),
        .total_ms      (total_ms)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one event to the show model and queue the frame it must produce
    task automatic step_show(input func_t kind, input logic [LEVEL_IN_W-1:0] lvl);
        logic [COUNT_W-1:0]   count_eff;
        logic [COUNT_W-1:0]   next_idx;
        logic [ELAPSED_W:0]   elapsed_sum;
        logic [TIME_W-1:0]    fade_ms;
        logic [63:0]          quot;
        logic [63:0]          sum_ms;
        logic                 ended;
        show_frame_t          frame;
        count_eff = (cfg_count > COUNT_W'(IMAGE_LIMIT)) ? COUNT_W'(IMAGE_LIMIT) : cfg_count;
        fade_ms   = cfg_cut ? '0 : cfg_trans;
        ended     = 1'b0;
        case (kind)
            FUNC_START:
            begin
                if (count_eff == 0)
                begin
                    show_running = 1'b0;
                    ended = 1'b1;
                end
                else
                begin
                    show_shown    = '0;
                    show_target   = '0;
                    show_in_trans = 1'b0;
                    show_elapsed  = '0;
                    show_level    = FULL_LEVEL;
                    show_running  = 1'b1;
                end
            end
            FUNC_STOP:
            begin
                show_running = 1'b0;
                show_level   = FULL_LEVEL;
            end
            FUNC_TICK:
            begin
                ticks_seen++;
                if (show_running && count_eff == 0)
                begin
                    show_running = 1'b0;
                    ended = 1'b1;
                end
                else if (show_running)
                begin
                    elapsed_sum = {1'b0, show_elapsed} + (ELAPSED_W+1)'(TICK_STEP);
                    show_elapsed = (elapsed_sum > {1'b0, ELAPSED_MAX}) ?
                                   ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
                    if (!show_in_trans)
                    begin
                        if (show_elapsed >= ELAPSED_W'(cfg_slide))
                        begin
                            next_idx = {1'b0, show_shown} + 1'b1;
                            if (next_idx >= count_eff && !cfg_loop)
                            begin
                                show_running = 1'b0;
                                ended = 1'b1;
                            end
                            else
                            begin
                                if (next_idx >= count_eff)
                                    show_wraps++;
                                show_target   = (next_idx >= count_eff) ? '0 : next_idx[7:0];
                                show_in_trans = 1'b1;
                                show_elapsed  = '0;
                            end
                        end
                    end
                    else if (show_elapsed >= ELAPSED_W'(fade_ms))
                    begin
                        show_shown    = show_target;
                        show_in_trans = 1'b0;
                        show_elapsed  = '0;
                    end
                end
            end
            default:
                show_level = (lvl > 16'(FULL_LEVEL)) ? FULL_LEVEL : lvl[LEVEL_W-1:0];
        endcase

        if (ended)
            show_ends++;
        if (show_shown > top_image)
            top_image = show_shown;

        frame.playing       = show_running;
        frame.finished      = ended;
        frame.current_image = show_shown;
        frame.next_valid    = show_in_trans;
        frame.next_image    = show_in_trans ? show_target : '0;
        if (!show_in_trans)
            frame.progress = '0;
        else if (fade_ms == 0)
            frame.progress = FULL_LEVEL;
        else
        begin
            quot = (64'(show_elapsed) * 64'(FULL_LEVEL)) / 64'(fade_ms);
            frame.progress = (quot > 64'(FULL_LEVEL)) ? FULL_LEVEL : quot[LEVEL_W-1:0];
        end
        frame.level_out = show_level;
        if (count_eff == 0)
            frame.total_ms = '0;
        else
        begin
            sum_ms = 64'(count_eff) * 64'(cfg_slide) + 64'(count_eff - 1) * 64'(cfg_trans);
            frame.total_ms = (sum_ms > TOTAL_SAT) ? TOTAL_SAT[TOTAL_W-1:0] : sum_ms[TOTAL_W-1:0];
        end
        expected_frames.push_back(frame);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_event(input func_t kind, input logic [LEVEL_IN_W-1:0] lvl);
        show_event_t ev;
        ev.kind  = kind;
        ev.level = lvl;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    // Register write; the model copy changes with it since the block is idle
    task automatic cfg_write(input cfg_index_t idx, input logic [TIME_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_IMAGE_COUNT:   cfg_count = value[COUNT_W-1:0];
            CFG_SLIDE_MS:      cfg_slide = value;
            CFG_TRANSITION_MS: cfg_trans = value;
            CFG_CUT_MODE:      cfg_cut   = value[0];
            CFG_LOOP_ENABLE:   cfg_loop  = value[0];
            default:           ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [COUNT_W-1:0] count, input logic [TIME_W-1:0] slide,
                              input logic [TIME_W-1:0] trans, input logic cut,
                              input logic loop_on);
        cfg_write(CFG_IMAGE_COUNT, TIME_W'(count));
        cfg_write(CFG_SLIDE_MS, slide);
        cfg_write(CFG_TRANSITION_MS, trans);
        cfg_write(CFG_CUT_MODE, TIME_W'(cut));
        cfg_write(CFG_LOOP_ENABLE, TIME_W'(loop_on));
    endtask

    // Sender holds until every queued event has its result, then settles
    task automatic wait_quiet();
        while (pending_events.size() != 0 || in_valid || expected_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '1;
        else if (pick < 15)
            return TIME_W'($urandom);
        else if (pick < 25)
            return '0;
        return TIME_W'($urandom_range(1, 200));
    endfunction

    function automatic logic [LEVEL_IN_W-1:0] random_level();
        if ($urandom_range(0, 1) == 0)
            return LEVEL_IN_W'($urandom_range(0, 4096));
        return LEVEL_IN_W'($urandom);
    endfunction

    // Stimulus: directed corners, long looping run, random phases
    initial
    begin
        int unsigned phase_items;
        int unsigned pick;
        logic [COUNT_W-1:0] rnd_count;

        cfg_count     = '0;
        cfg_slide     = SLIDE_MS_RST;
        cfg_trans     = TRANSITION_MS_RST;
        cfg_cut       = 1'b0;
        cfg_loop      = 1'b0;
        show_running  = 1'b0;
        show_in_trans = 1'b0;
        show_shown    = '0;
        show_target   = '0;
        show_elapsed  = '0;
        show_level    = FULL_LEVEL;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, no images: idle tick, empty start, level saturation
        queue_event(FUNC_TICK, 16'h0);
        queue_event(FUNC_START, 16'hFFFF);
        queue_event(FUNC_LEVEL, 16'hFFFF);
        queue_event(FUNC_LEVEL, 16'h0000);
        queue_event(FUNC_STOP, 16'h1234);
        wait_quiet();

        // three images: hold, fade, hold, into a second fade
        set_config(9'd3, 20'd66, 20'd66, 1'b0, 1'b0);
        queue_event(FUNC_START, 16'h0);
        repeat (7) queue_event(FUNC_TICK, 16'h0);
        wait_quiet();

        // shorter fade while fading: progress clamps; stop keeps the phase
        cfg_write(CFG_TRANSITION_MS, 20'd10);
        queue_event(FUNC_STOP, 16'h0);
        queue_event(FUNC_TICK, 16'h0);
        wait_quiet();

        // cut mode: full progress, then restart and cut through
        cfg_write(CFG_CUT_MODE, 20'd1);
        queue_event(FUNC_LEVEL, 16'd2048);
        queue_event(FUNC_START, 16'h0);
        repeat (3) queue_event(FUNC_TICK, 16'h0);
        wait_quiet();

        // count lowered below the current image: next step ends the show
        cfg_write(CFG_IMAGE_COUNT, 20'd1);
        repeat (2) queue_event(FUNC_TICK, 16'h0);
        wait_quiet();

        // looping over two images, then count cleared mid show
        cfg_write(CFG_IMAGE_COUNT, 20'd2);
        cfg_write(CFG_LOOP_ENABLE, 20'd1);
        queue_event(FUNC_START, 16'h0);
        repeat (6) queue_event(FUNC_TICK, 16'h0);
        wait_quiet();
        cfg_write(CFG_IMAGE_COUNT, 20'd0);
        queue_event(FUNC_TICK, 16'h0);
        wait_quiet();

        // oversized count, zero times: walk all 256 images and wrap
        set_config(9'h1FF, 20'd0, 20'd0, 1'b0, 1'b1);
        queue_event(FUNC_START, 16'h0);
        repeat (539)
        begin
            if ($urandom_range(0, 19) == 0)
                queue_event(FUNC_LEVEL, random_level());
            else
                queue_event(FUNC_TICK, 16'h0);
        end
        wait_quiet();

        // random phases; settings change only while the block is drained
        while (events_queued < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                rnd_count = COUNT_W'($urandom_range(0, 511));
            else if (pick < 15)
                rnd_count = COUNT_W'(IMAGE_LIMIT);
            else
                rnd_count = COUNT_W'($urandom_range(0, 5));
            set_config(rnd_count, random_time(), random_time(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) < 7)
                queue_event(FUNC_START, random_level());
            phase_items = $urandom_range(20, 60);
            repeat (phase_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    queue_event(FUNC_START, random_level());
                else if (pick < 12)
                    queue_event(FUNC_STOP, random_level());
                else if (pick < 26)
                    queue_event(FUNC_LEVEL, random_level());
                else
                    queue_event(FUNC_TICK, random_level());
            end
            wait_quiet();
        end

        $display("Events: %0d accepted, %0d ticks, %0d results checked",
                 events_accepted, ticks_seen, results_checked);
        $display("Shows ended: %0d, loop wraps: %0d, highest image shown: %0d",
                 show_ends, show_wraps, top_image);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Driver: bursts of items separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= FUNC_START;
            level_in <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                step_show(func_t'(func), level_in);
                events_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    next_event = pending_events.pop_front();
                    in_valid <= 1'b1;
                    func     <= next_event.kind;
                    level_in <= next_event.level;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 9) == 0) ?
                                     $urandom_range(40, 120) : $urandom_range(1, 8);
                        gap_left = $urandom_range(1, 20);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: randomly chosen ready pattern (always, random or sparse), plus periodic long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            rcv_cycles++;
            if (hold_off_left != 0)
            begin
                hold_off_left--;
                out_ready <= 1'b0;
            end
            else if (rcv_cycles % HOLD_OFF_PERIOD == HOLD_OFF_PERIOD / 2)
            begin
                hold_off_left = HOLD_OFF_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (rcv_cycles % 4 == 0);
                endcase
            end
            if (rcv_cycles % 128 == 0)
                ready_mode = $urandom_range(0, 2);
        end
    end

    // Monitor: in-order compare against the oldest expected frame
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t ns: result with no event pending, expected none, got image %0d",
                         $time, current_image);
                mismatches++;
            end
            else
            begin
                arrived_want = expected_frames.pop_front();
                check_field("playing", 32'(arrived_want.playing), 32'(playing));
                check_field("finished", 32'(arrived_want.finished), 32'(finished));
                check_field("current_image", 32'(arrived_want.current_image),
                            32'(current_image));
                check_field("next_valid", 32'(arrived_want.next_valid), 32'(next_valid));
                check_field("next_image", 32'(arrived_want.next_image), 32'(next_image));
                check_field("progress", 32'(arrived_want.progress), 32'(progress));
                check_field("level_out", 32'(arrived_want.level_out), 32'(level_out));
                check_field("total_ms", 32'(arrived_want.total_ms), 32'(total_ms));
                results_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_frames.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
